// ===== sv/sva_pkg.sv =====
package sva_pkg;

	localparam int POS_W = 6;
	localparam logic [4:0] CAP_RESET = 5'd16;

	typedef enum logic [2:0] {
		MODE_NOTE_ON   = 3'd0,
		MODE_NOTE_OFF  = 3'd1,
		MODE_KILL_NOTE = 3'd2,
		MODE_KILL_ALL  = 3'd3,
		MODE_RETIRE    = 3'd4
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [6:0]  note;
		logic [31:0] frequency;
		logic [31:0] amplitude;
		logic [31:0] pan;
		logic [47:0] start_time;
	} snd_entry_t;

	typedef struct packed {
		snd_entry_t  voice;
		logic [47:0] stop_time;
	} rel_entry_t;

	typedef struct packed {
		logic             shift;
		logic [POS_W-1:0] shift_from;
		logic             wr;
		logic [POS_W-1:0] wr_pos;
	} ctl_t;

endpackage

// ===== sv/synth_voice_allocator.sv =====
// Channel   Handshake           Payload
// input     in_valid/in_stall   mode, note, frequency_word, amplitude_word, pan_word,
//                               time_stamp, retire_list, retire_position
// output    out_valid/out_stall sounding_count, releasing_count, stole, stolen_note,
//                               moved_count, evicted_count
// config    cfg_we              cfg_wdata (voices_in_use)
//
// Note on, kill all and retire pass through the execute state once from transfer to result.
// Note off and kill note stay in the execute state while the sounding chain
// rotates one cell per cycle past its head, once for each sounding voice.
// One item at a time; in_stall is high while an item is in work or a result waits.
// arst_n clears both counts and sets voices_in_use to 16; voice cells hold no reset.
module synth_voice_allocator #(
	parameter int MAX_VOICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [6:0]  note,
	input  logic [31:0] frequency_word,
	input  logic [31:0] amplitude_word,
	input  logic [31:0] pan_word,
	input  logic [47:0] time_stamp,
	input  logic        retire_list,
	input  logic [3:0]  retire_position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  sounding_count,
	output logic [4:0]  releasing_count,
	output logic        stole,
	output logic [6:0]  stolen_note,
	output logic [4:0]  moved_count,
	output logic [4:0]  evicted_count
);

	localparam int CW = $clog2(MAX_VOICES + 1);
	localparam int PW = sva_pkg::POS_W;
	localparam int SW = $bits(sva_pkg::snd_entry_t);
	localparam int RW = $bits(sva_pkg::rel_entry_t);

	sva_pkg::state_t state_q, state_nxt;

	logic [4:0]    cap_cfg_q;
	logic [CW-1:0] cap;
	logic [CW-1:0] s_cnt_q, r_cnt_q, s_nxt, r_nxt;
	logic [CW-1:0] rem_q, rem_nxt, mv_q, mv_nxt, ev_q, ev_nxt;
	logic          stole_nxt;
	logic [6:0]    stolen_nxt;
	logic          finish, accept, rel_push;

	logic [2:0]  mode_q;
	logic [6:0]  note_q;
	logic [31:0] freq_q, amp_q, pan_q;
	logic [47:0] stamp_q;
	logic        rlist_q;
	logic [3:0]  rpos_q;

	logic        out_valid_q, stole_q;
	logic [4:0]  sc_q, rc_q, mc_q, ec_q;
	logic [6:0]  sn_q;

	sva_pkg::ctl_t       snd_ctl, rel_ctl;
	sva_pkg::snd_entry_t snd_wd, head;
	sva_pkg::rel_entry_t rel_wd;
	logic [SW-1:0]       snd_d [MAX_VOICES];
	logic [RW-1:0]       rel_d [MAX_VOICES];

	always_comb begin
		if (cap_cfg_q == 5'd0) begin
			cap = CW'(1);
		end else if (32'(cap_cfg_q) > 32'(MAX_VOICES)) begin
			cap = CW'(MAX_VOICES);
		end else begin
			cap = CW'(cap_cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q <= sva_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_cfg_q <= cfg_wdata;
		end
	end

	assign head = sva_pkg::snd_entry_t'(snd_d[0]);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sva_pkg::ST_IDLE: begin
				if (accept) state_nxt = sva_pkg::ST_EXEC;
			end
			sva_pkg::ST_EXEC: begin
				if (finish) state_nxt = sva_pkg::ST_IDLE;
			end
			default: state_nxt = sva_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != sva_pkg::ST_IDLE) || out_valid_q;
	end

	assign accept = in_valid && !in_stall;

	always_comb begin
		snd_ctl    = '0;
		rel_ctl    = '0;
		snd_wd     = '0;
		rel_wd     = '0;
		s_nxt      = s_cnt_q;
		r_nxt      = r_cnt_q;
		rem_nxt    = rem_q;
		mv_nxt     = mv_q;
		ev_nxt     = ev_q;
		stole_nxt  = 1'b0;
		stolen_nxt = 7'd0;
		finish     = 1'b0;
		rel_push   = 1'b0;
		if (state_q == sva_pkg::ST_EXEC) begin
			finish = 1'b1;
			case (mode_q)
				sva_pkg::MODE_NOTE_ON: begin
					snd_wd = '{note: note_q, frequency: freq_q, amplitude: amp_q,
						pan: pan_q, start_time: stamp_q};
					snd_ctl.wr = 1'b1;
					if (s_cnt_q >= cap) begin
						stole_nxt        = 1'b1;
						stolen_nxt       = head.note;
						mv_nxt           = CW'(1);
						rel_push         = 1'b1;
						rel_wd           = '{voice: head, stop_time: stamp_q};
						snd_ctl.shift    = 1'b1;
						snd_ctl.wr_pos   = PW'(s_cnt_q - CW'(1));
					end else begin
						snd_ctl.wr_pos = PW'(s_cnt_q);
						s_nxt          = s_cnt_q + CW'(1);
					end
				end
				sva_pkg::MODE_NOTE_OFF, sva_pkg::MODE_KILL_NOTE: begin
					if (rem_q != '0) begin
						finish        = 1'b0;
						rem_nxt       = rem_q - CW'(1);
						snd_ctl.shift = 1'b1;
						if (head.note == note_q) begin
							s_nxt  = s_cnt_q - CW'(1);
							mv_nxt = mv_q + CW'(1);
							if (mode_q == sva_pkg::MODE_NOTE_OFF) begin
								rel_push = 1'b1;
								rel_wd   = '{voice: head, stop_time: stamp_q};
							end
						end else begin
							snd_wd         = head;
							snd_ctl.wr     = 1'b1;
							snd_ctl.wr_pos = PW'(s_cnt_q - CW'(1));
						end
					end
				end
				sva_pkg::MODE_KILL_ALL: begin
					mv_nxt = s_cnt_q;
					s_nxt  = '0;
				end
				sva_pkg::MODE_RETIRE: begin
					if (!rlist_q) begin
						if (32'(rpos_q) < 32'(s_cnt_q)) begin
							snd_ctl.shift      = 1'b1;
							snd_ctl.shift_from = PW'(rpos_q);
							s_nxt              = s_cnt_q - CW'(1);
							mv_nxt             = CW'(1);
						end
					end else begin
						if (32'(rpos_q) < 32'(r_cnt_q)) begin
							rel_ctl.shift      = 1'b1;
							rel_ctl.shift_from = PW'(rpos_q);
							r_nxt              = r_cnt_q - CW'(1);
							mv_nxt             = CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
			if (rel_push) begin
				rel_ctl.wr = 1'b1;
				if (r_cnt_q >= cap) begin
					rel_ctl.shift  = 1'b1;
					rel_ctl.wr_pos = PW'(r_cnt_q - CW'(1));
					ev_nxt         = ev_q + CW'(1);
				end else begin
					rel_ctl.wr_pos = PW'(r_cnt_q);
					r_nxt          = r_cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sva_pkg::ST_IDLE;
			s_cnt_q <= '0;
			r_cnt_q <= '0;
			rem_q   <= '0;
			mv_q    <= '0;
			ev_q    <= '0;
		end else begin
			state_q <= state_nxt;
			s_cnt_q <= s_nxt;
			r_cnt_q <= r_nxt;
			if (accept) begin
				rem_q <= s_cnt_q;
				mv_q  <= '0;
				ev_q  <= '0;
			end else begin
				rem_q <= rem_nxt;
				mv_q  <= mv_nxt;
				ev_q  <= ev_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			note_q  <= note;
			freq_q  <= frequency_word;
			amp_q   <= amplitude_word;
			pan_q   <= pan_word;
			stamp_q <= time_stamp;
			rlist_q <= retire_list;
			rpos_q  <= retire_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sc_q    <= 5'(s_nxt);
			rc_q    <= 5'(r_nxt);
			stole_q <= stole_nxt;
			sn_q    <= stolen_nxt;
			mc_q    <= 5'(mv_nxt);
			ec_q    <= 5'(ev_nxt);
		end
	end

	assign out_valid       = out_valid_q;
	assign sounding_count  = sc_q;
	assign releasing_count = rc_q;
	assign stole           = stole_q;
	assign stolen_note     = sn_q;
	assign moved_count     = mc_q;
	assign evicted_count   = ec_q;

	for (genvar i = 0; i < MAX_VOICES; i++) begin : g_cell
		logic [SW-1:0] snd_up;
		logic [RW-1:0] rel_up;
		if (i == MAX_VOICES - 1) begin : g_last
			assign snd_up = snd_d[i];
			assign rel_up = rel_d[i];
		end else begin : g_mid
			assign snd_up = snd_d[i+1];
			assign rel_up = rel_d[i+1];
		end
		sva_cell #(.W(SW), .IDX(i)) u_snd (
			.clk     (clk),
			.ctl     (snd_ctl),
			.up_data (snd_up),
			.wr_data (snd_wd),
			.data    (snd_d[i])
		);
		sva_cell #(.W(RW), .IDX(i)) u_rel (
			.clk     (clk),
			.ctl     (rel_ctl),
			.up_data (rel_up),
			.wr_data (rel_wd),
			.data    (rel_d[i])
		);
	end

`ifndef ASSERT_OFF
	a_snd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(s_cnt_q) <= 32'(MAX_VOICES))
		else $error("sounding count over size");
	a_rel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(r_cnt_q) <= 32'(MAX_VOICES))
		else $error("releasing count over size");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sva_pkg::ST_IDLE |=> s_cnt_q == $past(s_cnt_q) &&
		r_cnt_q == $past(r_cnt_q))
		else $error("counts changed while idle");
`endif

endmodule

// ===== sv/sva_cell.sv =====
module sva_cell #(
	parameter int W   = 8,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  sva_pkg::ctl_t ctl,
	input  logic [W-1:0]  up_data,
	input  logic [W-1:0]  wr_data,
	output logic [W-1:0]  data
);

	localparam logic [sva_pkg::POS_W-1:0] ME = sva_pkg::POS_W'(IDX);

	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && ctl.wr_pos == ME) begin
			data_q <= wr_data;
		end else if (ctl.shift && ME >= ctl.shift_from) begin
			data_q <= up_data;
		end
	end

	assign data = data_q;

endmodule

// ===== tb/sv/synth_voice_allocator_tb.sv =====
module synth_voice_allocator_tb;

	localparam int NV = 16;

	typedef struct packed {
		logic [2:0]  mode;
		logic [6:0]  note;
		logic [31:0] freq;
		logic [31:0] ampl;
		logic [31:0] pan;
		logic [47:0] stamp;
		logic        rlist;
		logic [3:0]  rpos;
	} event_t;

	typedef struct packed {
		logic [4:0] scount;
		logic [4:0] rcount;
		logic       stole;
		logic [6:0] snote;
		logic [4:0] moved;
		logic [4:0] evicted;
	} tally_t;

	typedef struct {
		event_t ev;
		logic   known;
		tally_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	event_t      drv;
	logic        out_valid;
	logic        out_stall;
	tally_t      got;

	synth_voice_allocator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(drv.mode), .note(drv.note), .frequency_word(drv.freq),
		.amplitude_word(drv.ampl), .pan_word(drv.pan), .time_stamp(drv.stamp),
		.retire_list(drv.rlist), .retire_position(drv.rpos),
		.out_valid(out_valid), .out_stall(out_stall),
		.sounding_count(got.scount), .releasing_count(got.rcount),
		.stole(got.stole), .stolen_note(got.snote),
		.moved_count(got.moved), .evicted_count(got.evicted)
	);

	// predictor state
	logic [4:0]  cap_reg;
	logic [6:0]  s_note [NV];
	logic [47:0] s_start [NV];
	logic [6:0]  r_note [NV];
	logic [47:0] r_end [NV];
	int          s_cnt, r_cnt;

	tally_t expected_tallies [$];
	int     errors;
	logic   hold_off;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int eff_cap();
		if (cap_reg == 0) return 1;
		if (cap_reg > NV) return NV;
		return int'(cap_reg);
	endfunction

	function automatic void drop_sounding(int p);
		for (int i = p; i + 1 < s_cnt; i++) begin
			s_note[i] = s_note[i + 1];
			s_start[i] = s_start[i + 1];
		end
		s_cnt--;
	endfunction

	function automatic void drop_releasing(int p);
		for (int i = p; i + 1 < r_cnt; i++) begin
			r_note[i] = r_note[i + 1];
			r_end[i] = r_end[i + 1];
		end
		r_cnt--;
	endfunction

	function automatic int release_voice(int p, logic [47:0] t);
		int ev;
		ev = 0;
		if (r_cnt >= eff_cap() && r_cnt > 0) begin
			drop_releasing(0);
			ev = 1;
		end
		if (r_cnt >= NV) return ev;
		r_note[r_cnt] = s_note[p];
		r_end[r_cnt] = t;
		r_cnt++;
		drop_sounding(p);
		return ev;
	endfunction

	function automatic tally_t allocate(event_t e);
		tally_t r;
		int     i;
		r = '0;
		case (e.mode)
			sva_pkg::MODE_NOTE_ON: begin
				if (s_cnt >= eff_cap() && s_cnt > 0) begin
					r.stole = 1'b1;
					r.snote = s_note[0];
					r.evicted = 5'(release_voice(0, e.stamp));
					r.moved = 5'd1;
				end
				if (s_cnt < NV) begin
					s_note[s_cnt] = e.note;
					s_start[s_cnt] = e.stamp;
					s_cnt++;
				end
			end
			sva_pkg::MODE_NOTE_OFF, sva_pkg::MODE_KILL_NOTE: begin
				i = 0;
				while (i < s_cnt) begin
					if (s_note[i] == e.note) begin
						if (e.mode == sva_pkg::MODE_NOTE_OFF)
							r.evicted = r.evicted + 5'(release_voice(i, e.stamp));
						else
							drop_sounding(i);
						r.moved++;
					end else
						i++;
				end
			end
			sva_pkg::MODE_KILL_ALL: begin
				r.moved = 5'(s_cnt);
				s_cnt = 0;
			end
			sva_pkg::MODE_RETIRE: begin
				if (!e.rlist && e.rpos < s_cnt) begin
					drop_sounding(int'(e.rpos));
					r.moved = 5'd1;
				end else if (e.rlist && e.rpos < r_cnt) begin
					drop_releasing(int'(e.rpos));
					r.moved = 5'd1;
				end
			end
			default: ;
		endcase
		r.scount = 5'(s_cnt);
		r.rcount = 5'(r_cnt);
		return r;
	endfunction

	task automatic report(string what, logic [47:0] g, logic [47:0] w);
		$display("mismatch %s: got %0d want %0d at %0t", what, g, w, $realtime);
		errors++;
	endtask

	// receiver
	initial begin
		out_stall = 1;
		@(negedge clk);
		forever begin
			@(negedge clk);
			if (hold_off) out_stall <= 1;
			else out_stall <= (($urandom & 7) < 2) && ($urandom & 1);
		end
	end

	always @(posedge clk) begin
		tally_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tallies.size() == 0) begin
				report("extra transfer", 48'd1, 48'd0);
			end else begin
				w = expected_tallies.pop_front();
				if (got.scount !== w.scount) report("sounding_count", got.scount, w.scount);
				if (got.rcount !== w.rcount) report("releasing_count", got.rcount, w.rcount);
				if (got.stole !== w.stole) report("stole", got.stole, w.stole);
				if (got.snote !== w.snote) report("stolen_note", got.snote, w.snote);
				if (got.moved !== w.moved) report("moved_count", got.moved, w.moved);
				if (got.evicted !== w.evicted)
					report("evicted_count", got.evicted, w.evicted);
			end
		end
	end

	task automatic send(row_t row);
		tally_t w;
		drv <= row.ev;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		w = allocate(row.ev);
		if (row.known && w !== row.res) report("table row", 48'(w), 48'(row.res));
		expected_tallies.push_back(w);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_tallies.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_cap(logic [4:0] v);
		cfg_wdata <= v;
		cfg_we <= 1;
		@(negedge clk);
		cfg_we <= 0;
		cap_reg = v;
	endtask

	function automatic event_t mk(logic [2:0] m, logic [6:0] n, logic [47:0] t,
			logic rl, logic [3:0] rp);
		event_t e;
		e.mode = m;
		e.note = n;
		e.freq = {$urandom};
		e.ampl = {$urandom};
		e.pan = {$urandom};
		e.stamp = t;
		e.rlist = rl;
		e.rpos = rp;
		return e;
	endfunction

	function automatic event_t rand_event(int pool);
		event_t e;
		int     k;
		e = mk(sva_pkg::MODE_NOTE_ON, 7'($urandom_range(0, pool)), 48'({$urandom, $urandom}),
			1'($urandom & 1), 4'($urandom));
		k = $urandom_range(0, 99);
		if (k < 45) e.mode = sva_pkg::MODE_NOTE_ON;
		else if (k < 70) e.mode = sva_pkg::MODE_NOTE_OFF;
		else if (k < 80) e.mode = sva_pkg::MODE_KILL_NOTE;
		else if (k < 83) e.mode = sva_pkg::MODE_KILL_ALL;
		else if (k < 97) e.mode = sva_pkg::MODE_RETIRE;
		else e.mode = 3'($urandom_range(5, 7));
		return e;
	endfunction

	initial begin
		row_t        dir [$];
		row_t        r;
		logic [4:0]  caps [6];
		int          burst;
		errors = 0;
		hold_off = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_valid = 0;
		drv = '0;
		cap_reg = sva_pkg::CAP_RESET;
		s_cnt = 0;
		r_cnt = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		r.known = 1;
		r.ev = mk(sva_pkg::MODE_KILL_ALL, 7'd0, 48'd0, 1'b0, 4'd0);
		r.res = '0;
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_RETIRE, 7'd0, 48'd0, 1'b1, 4'd15);
		dir.push_back(r);
		r.ev = mk(3'd7, 7'd127, '1, 1'b1, 4'd15);
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_NOTE_ON, 7'd127, '1, 1'b0, 4'd0);
		r.ev.freq = '1; r.ev.ampl = '1; r.ev.pan = '1;
		r.res = '0; r.res.scount = 5'd1;
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_NOTE_ON, 7'd0, 48'd0, 1'b1, 4'd15);
		r.ev.freq = '0; r.ev.ampl = '0; r.ev.pan = '0;
		r.res.scount = 5'd2;
		dir.push_back(r);
		r.known = 0;
		for (int i = 0; i < 16; i++) begin
			r.ev = mk(sva_pkg::MODE_NOTE_ON, 7'(i % 3), 48'(i), 1'b0, 4'd0);
			dir.push_back(r);
		end
		r.ev = mk(sva_pkg::MODE_NOTE_OFF, 7'd1, '1, 1'b0, 4'd0);
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_KILL_NOTE, 7'd2, 48'd0, 1'b0, 4'd0);
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_RETIRE, 7'd0, 48'd0, 1'b0, 4'd0);
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_RETIRE, 7'd0, 48'd0, 1'b1, 4'd0);
		dir.push_back(r);
		r.ev = mk(sva_pkg::MODE_NOTE_OFF, 7'd0, 48'd5, 1'b0, 4'd0);
		dir.push_back(r);

		foreach (dir[i]) send(dir[i]);
		drain();

		caps = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd17, 5'd16};
		r.known = 0;
		foreach (caps[c]) begin
			set_cap(caps[c]);
			for (int n = 0; n < 340;) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < 340; b++, n++) begin
					r.ev = rand_event(c == 2 ? 127 : 6);
					send(r);
				end
				if ($urandom & 1) pause_sender();
				if (c == 3 && n > 100 && n < 130) begin
					hold_off = 1;
					fork
						begin
							repeat (200) @(negedge clk);
							hold_off = 0;
						end
					join_none
				end
			end
			drain();
		end
		set_cap(5'd16);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
